>>> src/pmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_pkg
// types and constants for the planar mirror ray reflect pipeline
// ----------------------------------------------------------------------------
package pmr_pkg;

    localparam int POS_W    = 32;
    localparam int DIR_W    = 18;
    localparam int PATH_W   = 32;
    localparam int BNC_W    = 8;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 8;
    localparam int RAD_W    = 31;

    localparam int IN_W     = 232;
    localparam int OUT_W    = 264;

    // divider: 50 quotient bits, 5 per stage
    localparam int DIV_W     = 50;
    localparam int DEN_W     = 18;
    localparam int DIV_BITS  = 5;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int LANES     = 3;

    localparam logic [IDX_W-1:0] REG_PLANE_HEIGHT    = 8'd0;
    localparam logic [IDX_W-1:0] REG_APERTURE_RADIUS = 8'd1;
    localparam logic [IDX_W-1:0] REG_FRESNEL_RE      = 8'd2;
    localparam logic [IDX_W-1:0] REG_FRESNEL_IM      = 8'd3;

    localparam logic signed [DIR_W-1:0] FRESNEL_RE_RST = 18'sd65536;
    localparam logic signed [DIR_W-1:0] DIR_MIN        = -18'sd131072;
    localparam logic signed [DIR_W-1:0] DIR_MAX        = 18'sd131071;

    typedef struct packed {
        logic [BNC_W-1:0]         bounces;
        logic [PATH_W-1:0]        path_len;
        logic signed [DIR_W-1:0]  amp_im;
        logic signed [DIR_W-1:0]  amp_re;
        logic signed [DIR_W-1:0]  dir_z;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } ray_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
    } dv_t;

endpackage

>>> src/planar_mirror_ray_reflect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_mirror_ray_reflect
// intersects rays with a circular planar mirror and reflects the hits
// ----------------------------------------------------------------------------
// path: stages a, b and c, then the 10-stage radix-2 divider (5 quotient bits
// per stage, three lanes side by side), then stages e, f, g and the output register
// throughput: one ray per cycle while the output is not stalled, every stage is pipelined
// a stall on the output holds every stage in place
// reset clears all valid bits, the hit counter and the registers to defaults
// ----------------------------------------------------------------------------
module planar_mirror_ray_reflect
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pmr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pmr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, amp_re, amp_im, path_len, bounces
    input  logic [pmr_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_dir_x, out_dir_y, out_dir_z,
    // out_amp_re, out_amp_im, out_path_len, out_bounces, hit_total
    output logic [pmr_pkg::OUT_W-1:0]   m_tdata,
    // reflected
    output logic                        m_tuser
);

    localparam int NS = pmr_pkg::DIV_STEPS;

    function automatic pmr_pkg::dv_t div_step(input pmr_pkg::dv_t x,
                                              input logic [pmr_pkg::DEN_W-1:0] den);
        pmr_pkg::dv_t           y;
        logic [pmr_pkg::DEN_W:0] r;
        y = x;
        for (int i = 0; i < pmr_pkg::DIV_BITS; i++)
        begin
            r     = {y.rem, y.num[pmr_pkg::DIV_W-1]};
            y.num = {y.num[pmr_pkg::DIV_W-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                y.rem = pmr_pkg::DEN_W'(r - {1'b0, den});
                y.quo = {y.quo[pmr_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                y.rem = r[pmr_pkg::DEN_W-1:0];
                y.quo = {y.quo[pmr_pkg::DIV_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic logic signed [17:0] round_sat(input logic signed [36:0] v);
        logic signed [37:0] s;
        logic signed [21:0] r;
        s = 38'(v) + 38'sd32768;
        r = 22'(s >>> 16);
        if (r > 22'sd65536)
            return 18'sd65536;
        else if (r < -22'sd65536)
            return -18'sd65536;
        else
            return r[17:0];
    endfunction

    // configuration
    logic signed [31:0] plane_height_reg;
    logic [30:0]        aperture_radius_reg;
    logic signed [17:0] fresnel_re_reg;
    logic signed [17:0] fresnel_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_height_reg    <= '0;
            aperture_radius_reg <= '0;
            fresnel_re_reg      <= pmr_pkg::FRESNEL_RE_RST;
            fresnel_im_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pmr_pkg::REG_PLANE_HEIGHT:    plane_height_reg    <= cfg_data;
                pmr_pkg::REG_APERTURE_RADIUS: aperture_radius_reg <= cfg_data[30:0];
                pmr_pkg::REG_FRESNEL_RE:      fresnel_re_reg      <= cfg_data[17:0];
                pmr_pkg::REG_FRESNEL_IM:      fresnel_im_reg      <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic ce;
    logic a_valid_reg, b_valid_reg, c_valid_reg, e_valid_reg, f_valid_reg;
    logic g_valid_reg, o_valid_reg;
    logic dv_valid_reg [0:NS];

    pmr_pkg::ray_t a_ray_reg, b_ray_reg, c_ray_reg, e_ray_reg, f_ray_reg, g_ray_reg;
    pmr_pkg::ray_t dv_ray_reg [0:NS];

    logic signed [32:0] b_d_reg;
    logic signed [32:0] c_d_reg;
    logic signed [50:0] c_nx_reg;
    logic signed [50:0] c_ny_reg;

    pmr_pkg::dv_t               dv_reg  [0:NS][0:pmr_pkg::LANES-1];
    pmr_pkg::dv_t               dv_next [0:NS-1][0:pmr_pkg::LANES-1];
    logic [pmr_pkg::DEN_W-1:0]  dv_den_reg [0:NS];
    logic [pmr_pkg::LANES-1:0]  dv_neg_reg [0:NS];

    logic signed [50:0] e_t_reg;
    logic signed [51:0] e_cx_reg;
    logic signed [51:0] e_cy_reg;
    logic               e_dz_nz_reg;

    logic               f_pre_hit_reg;
    logic [30:0]        f_ux_reg;
    logic [30:0]        f_uy_reg;
    logic [49:0]        f_t_reg;
    logic signed [31:0] f_cx_reg;
    logic signed [31:0] f_cy_reg;

    logic               g_pre_hit_reg;
    logic [61:0]        g_sx_reg;
    logic [61:0]        g_sy_reg;
    logic [61:0]        g_r2_reg;
    logic signed [35:0] g_rr_reg, g_ii_reg, g_ri_reg, g_ir_reg;
    logic [49:0]        g_t_reg;
    logic signed [31:0] g_cx_reg;
    logic signed [31:0] g_cy_reg;

    logic [31:0]        cnt_reg;
    logic [31:0]        cnt_next;
    pmr_pkg::ray_t      o_ray_reg;
    pmr_pkg::ray_t      o_ray_next;
    logic               o_hit_reg;
    logic               o_hit_next;
    logic [31:0]        o_cnt_reg;

    assign ce       = !o_valid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int k = 0; k <= NS; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg     <= s_tvalid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            dv_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k <= NS; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            e_valid_reg     <= dv_valid_reg[NS];
            f_valid_reg     <= e_valid_reg;
            g_valid_reg     <= f_valid_reg;
            o_valid_reg     <= g_valid_reg;
            cnt_reg         <= cnt_next;
        end
    end

    // divider steps
    always_comb
    begin
        for (int k = 0; k < NS; k++)
            for (int l = 0; l < pmr_pkg::LANES; l++)
                dv_next[k][l] = div_step(dv_reg[k][l], dv_den_reg[k]);
    end

    // front end: distance, products, divider setup
    logic [32:0]        d_mag;
    logic signed [50:0] nx_abs;
    logic signed [50:0] ny_abs;
    always_comb
    begin
        d_mag  = c_d_reg[32] ? 33'(-c_d_reg) : 33'(c_d_reg);
        nx_abs = c_nx_reg[50] ? -c_nx_reg : c_nx_reg;
        ny_abs = c_ny_reg[50] ? -c_ny_reg : c_ny_reg;
    end

    // back end
    logic [49:0]        q_t, q_x, q_y;
    logic signed [51:0] qx_s, qy_s;
    logic signed [51:0] rad_s;
    logic signed [51:0] ax, ay;
    logic               in_range;
    logic               t_ok;
    logic [62:0]        r2_sum;
    logic               hit;
    logic [50:0]        path_sum;

    always_comb
    begin
        q_t   = dv_reg[NS][0].quo;
        q_x   = dv_reg[NS][1].quo;
        q_y   = dv_reg[NS][2].quo;
        qx_s  = dv_neg_reg[NS][1] ? -$signed({2'b00, q_x}) : $signed({2'b00, q_x});
        qy_s  = dv_neg_reg[NS][2] ? -$signed({2'b00, q_y}) : $signed({2'b00, q_y});

        rad_s    = $signed({21'b0, aperture_radius_reg});
        in_range = (e_cx_reg <= rad_s) && (e_cx_reg >= -rad_s)
                && (e_cy_reg <= rad_s) && (e_cy_reg >= -rad_s);
        t_ok     = !e_t_reg[50] && (e_t_reg != '0);
        ax       = e_cx_reg[51] ? -e_cx_reg : e_cx_reg;
        ay       = e_cy_reg[51] ? -e_cy_reg : e_cy_reg;

        r2_sum   = {1'b0, g_sx_reg} + {1'b0, g_sy_reg};
        hit      = g_pre_hit_reg && (r2_sum <= {1'b0, g_r2_reg});
        path_sum = {19'b0, g_ray_reg.path_len} + {1'b0, g_t_reg};

        o_ray_next = g_ray_reg;
        o_hit_next = g_valid_reg && hit;
        cnt_next   = cnt_reg + {31'b0, o_hit_next};
        if (hit)
        begin
            o_ray_next.pos_x  = g_cx_reg;
            o_ray_next.pos_y  = g_cy_reg;
            o_ray_next.pos_z  = plane_height_reg;
            o_ray_next.dir_z  = (g_ray_reg.dir_z == pmr_pkg::DIR_MIN) ? pmr_pkg::DIR_MAX
                                                                       : -g_ray_reg.dir_z;
            o_ray_next.amp_re = round_sat(37'(g_rr_reg) - 37'(g_ii_reg));
            o_ray_next.amp_im = round_sat(37'(g_ri_reg) + 37'(g_ir_reg));
            o_ray_next.path_len = (path_sum > 51'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : path_sum[31:0];
            o_ray_next.bounces  = (g_ray_reg.bounces == 8'hFF) ? 8'hFF
                                                               : g_ray_reg.bounces + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_ray_reg <= s_tdata[225:0];

            b_ray_reg <= a_ray_reg;
            b_d_reg   <= 33'(plane_height_reg) - 33'(a_ray_reg.pos_z);

            c_ray_reg <= b_ray_reg;
            c_d_reg   <= b_d_reg;
            c_nx_reg  <= 51'(b_d_reg) * 51'(b_ray_reg.dir_x);
            c_ny_reg  <= 51'(b_d_reg) * 51'(b_ray_reg.dir_y);

            dv_ray_reg[0]    <= c_ray_reg;
            dv_den_reg[0]    <= c_ray_reg.dir_z[17] ? 18'(-c_ray_reg.dir_z)
                                                    : 18'(c_ray_reg.dir_z);
            dv_neg_reg[0]    <= {c_ny_reg[50] ^ c_ray_reg.dir_z[17],
                                 c_nx_reg[50] ^ c_ray_reg.dir_z[17],
                                 c_d_reg[32]  ^ c_ray_reg.dir_z[17]};
            dv_reg[0][0]     <= '{rem: '0, num: {1'b0, d_mag, 16'b0}, quo: '0};
            dv_reg[0][1]     <= '{rem: '0, num: nx_abs[49:0], quo: '0};
            dv_reg[0][2]     <= '{rem: '0, num: ny_abs[49:0], quo: '0};
            for (int k = 1; k <= NS; k++)
            begin
                dv_ray_reg[k] <= dv_ray_reg[k-1];
                dv_den_reg[k] <= dv_den_reg[k-1];
                dv_neg_reg[k] <= dv_neg_reg[k-1];
                for (int l = 0; l < pmr_pkg::LANES; l++)
                    dv_reg[k][l] <= dv_next[k-1][l];
            end

            e_ray_reg   <= dv_ray_reg[NS];
            e_dz_nz_reg <= dv_ray_reg[NS].dir_z != '0;
            e_t_reg     <= dv_neg_reg[NS][0] ? -$signed({1'b0, q_t}) : $signed({1'b0, q_t});
            e_cx_reg    <= 52'(dv_ray_reg[NS].pos_x) + qx_s;
            e_cy_reg    <= 52'(dv_ray_reg[NS].pos_y) + qy_s;

            f_ray_reg     <= e_ray_reg;
            f_pre_hit_reg <= e_dz_nz_reg && t_ok && in_range;
            f_ux_reg      <= ax[30:0];
            f_uy_reg      <= ay[30:0];
            f_t_reg       <= e_t_reg[49:0];
            f_cx_reg      <= e_cx_reg[31:0];
            f_cy_reg      <= e_cy_reg[31:0];

            g_ray_reg     <= f_ray_reg;
            g_pre_hit_reg <= f_pre_hit_reg;
            g_sx_reg      <= 62'(f_ux_reg) * 62'(f_ux_reg);
            g_sy_reg      <= 62'(f_uy_reg) * 62'(f_uy_reg);
            g_r2_reg      <= 62'(aperture_radius_reg) * 62'(aperture_radius_reg);
            g_rr_reg      <= 36'(f_ray_reg.amp_re) * 36'(fresnel_re_reg);
            g_ii_reg      <= 36'(f_ray_reg.amp_im) * 36'(fresnel_im_reg);
            g_ri_reg      <= 36'(f_ray_reg.amp_re) * 36'(fresnel_im_reg);
            g_ir_reg      <= 36'(f_ray_reg.amp_im) * 36'(fresnel_re_reg);
            g_t_reg       <= f_t_reg;
            g_cx_reg      <= f_cx_reg;
            g_cy_reg      <= f_cy_reg;

            o_ray_reg <= o_ray_next;
            o_hit_reg <= o_hit_next;
            o_cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_hit_reg;
    assign m_tdata  = {6'b0, o_cnt_reg, o_ray_reg};

endmodule

>>> tb/tb_planar_mirror_ray_reflect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_mirror_ray_reflect
// streams rays through the mirror pipeline under random stalls on both
// sides, predicts each result in the bench and compares the whole beat and m_tuser
// ----------------------------------------------------------------------------
module tb_planar_mirror_ray_reflect;

    typedef struct packed {
        logic [pmr_pkg::CNT_W-1:0]         hit_total;
        logic [pmr_pkg::BNC_W-1:0]         bounces;
        logic [pmr_pkg::PATH_W-1:0]        path_len;
        logic signed [pmr_pkg::DIR_W-1:0]  amp_im;
        logic signed [pmr_pkg::DIR_W-1:0]  amp_re;
        logic signed [pmr_pkg::DIR_W-1:0]  dir_z;
        logic signed [pmr_pkg::DIR_W-1:0]  dir_y;
        logic signed [pmr_pkg::DIR_W-1:0]  dir_x;
        logic signed [pmr_pkg::POS_W-1:0]  pos_z;
        logic signed [pmr_pkg::POS_W-1:0]  pos_y;
        logic signed [pmr_pkg::POS_W-1:0]  pos_x;
    } bounce_t;

    typedef struct {
        bounce_t ray;
        logic    refl;
    } outcome_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [pmr_pkg::IDX_W-1:0] cfg_index;
    logic [pmr_pkg::CFG_W-1:0] cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [pmr_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [pmr_pkg::OUT_W-1:0] m_tdata;
    logic                      m_tuser;

    planar_mirror_ray_reflect DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // mirror registers as the bench sees them
    logic signed [63:0] mir_z;
    logic [63:0]        mir_rad;
    logic signed [63:0] fr_re;
    logic signed [63:0] fr_im;
    logic [31:0]        hit_count;

    pmr_pkg::ray_t ray_q[$];
    outcome_t      bounce_q[$];
    int            fails;
    int            sent;
    int            got;
    bit            calm;
    bit            hold_long;
    int            src_gap;
    int            snk_gap;
    int            hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [63:0] fdiv(input logic signed [63:0] v);
        if (v >= 0)
            return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic logic signed [63:0] amp_round(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = fdiv(v + 32768);
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return r;
    endfunction

    // next ray through the mirror, updates the hit count
    function automatic outcome_t reflect_ray(input pmr_pkg::ray_t r);
        outcome_t           o;
        logic signed [63:0] px, py, pz, dx, dy, dz, ar, ai, d, t, cx, cy, nz, nr, ni;
        logic [63:0]        ux, uy, npath;
        px = r.pos_x; py = r.pos_y; pz = r.pos_z;
        dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
        ar = r.amp_re; ai = r.amp_im;
        o.refl = 1'b0;
        o.ray.pos_x = r.pos_x; o.ray.pos_y = r.pos_y; o.ray.pos_z = r.pos_z;
        o.ray.dir_x = r.dir_x; o.ray.dir_y = r.dir_y; o.ray.dir_z = r.dir_z;
        o.ray.amp_re = r.amp_re; o.ray.amp_im = r.amp_im;
        o.ray.path_len = r.path_len; o.ray.bounces = r.bounces;
        if (dz != 0)
        begin
            d = mir_z - pz;
            t = (d * 65536) / dz;
            if (t >= 1)
            begin
                cx = px + (d * dx) / dz;
                cy = py + (d * dy) / dz;
                if (cx <= $signed(mir_rad) && cx >= -$signed(mir_rad)
                    && cy <= $signed(mir_rad) && cy >= -$signed(mir_rad))
                begin
                    ux = cx < 0 ? -cx : cx;
                    uy = cy < 0 ? -cy : cy;
                    if (ux * ux + uy * uy <= mir_rad * mir_rad)
                    begin
                        o.refl = 1'b1;
                        o.ray.pos_x = cx[31:0];
                        o.ray.pos_y = cy[31:0];
                        o.ray.pos_z = mir_z[31:0];
                        nz = -dz;
                        if (nz > 131071)
                            nz = 131071;
                        o.ray.dir_z = nz[17:0];
                        nr = amp_round(ar * fr_re - ai * fr_im);
                        ni = amp_round(ar * fr_im + ai * fr_re);
                        o.ray.amp_re = nr[17:0];
                        o.ray.amp_im = ni[17:0];
                        npath = {32'd0, r.path_len} + t;
                        o.ray.path_len = npath > 64'hFFFF_FFFF ? 32'hFFFF_FFFF
                                                               : npath[31:0];
                        o.ray.bounces = r.bounces == 8'hFF ? 8'hFF : r.bounces + 8'd1;
                        hit_count = hit_count + 32'd1;
                    end
                end
            end
        end
        o.ray.hit_total = hit_count;
        return o;
    endfunction

    task automatic write_reg(input logic [pmr_pkg::IDX_W-1:0] idx,
                             input logic [pmr_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            pmr_pkg::REG_PLANE_HEIGHT:    mir_z   = $signed(val);
            pmr_pkg::REG_APERTURE_RADIUS: mir_rad = {33'd0, val[30:0]};
            pmr_pkg::REG_FRESNEL_RE:      fr_re   = $signed(val[17:0]);
            pmr_pkg::REG_FRESNEL_IM:      fr_im   = $signed(val[17:0]);
            default: ;
        endcase
    endtask

    task automatic set_mirror(input logic [31:0] z, input logic [31:0] rad,
                              input logic [17:0] re, input logic [17:0] im);
        write_reg(pmr_pkg::REG_PLANE_HEIGHT, z);
        write_reg(pmr_pkg::REG_APERTURE_RADIUS, rad);
        write_reg(pmr_pkg::REG_FRESNEL_RE, {14'd0, re});
        write_reg(pmr_pkg::REG_FRESNEL_IM, {14'd0, im});
    endtask

    function automatic logic [17:0] rnd_unit();
        case ($urandom_range(0, 5))
            0: return 18'h20000;
            1: return 18'h1FFFF;
            2: return 18'd65536;
            3: return -18'sd65536;
            default: return 18'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    // random ray; when aimed, placed near the mirror so that most are hits
    function automatic pmr_pkg::ray_t rnd_ray(input bit aimed);
        pmr_pkg::ray_t r;
        int            span;
        r.pos_x    = $urandom;
        r.pos_y    = $urandom;
        r.pos_z    = $urandom;
        r.dir_x    = rnd_unit();
        r.dir_y    = rnd_unit();
        r.dir_z    = rnd_unit();
        r.amp_re   = rnd_unit();
        r.amp_im   = rnd_unit();
        r.path_len = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                               : $urandom;
        r.bounces  = 8'($urandom);
        if (aimed)
        begin
            span    = (mir_rad > 0) ? int'(mir_rad[30:0] / 2) : 1;
            r.pos_x = $signed(mir_rad[30:0]) / 3 - $urandom_range(0, span);
            r.pos_y = $urandom_range(0, span) - span / 2;
            r.pos_z = mir_z[31:0] - $urandom_range(1, 1 << 18) * (r.dir_z[17] ? -1 : 1);
            r.dir_x = 18'($urandom_range(0, 2000) - 1000);
            r.dir_y = 18'($urandom_range(0, 2000) - 1000);
            if (r.dir_z == 0)
                r.dir_z = 18'd60000;
        end
        return r;
    endfunction

    task automatic drain();
        while (ray_q.size() != 0 || bounce_q.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                bounce_q.push_back(reflect_ray(pmr_pkg::ray_t'(s_tdata[225:0])));
                sent = sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (ray_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pmr_pkg::IN_W'(ray_q.pop_front());
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 6);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
            hold_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = got + 1;
                if (bounce_q.size() == 0)
                begin
                    $display("%t: unexpected beat %h", $realtime, m_tdata);
                    fails = fails + 1;
                end
                else
                begin
                    outcome_t e;
                    e = bounce_q.pop_front();
                    if (m_tdata !== pmr_pkg::OUT_W'(e.ray) || m_tuser !== e.refl)
                    begin
                        $display("%t: mismatch expected %h/%b actual %h/%b", $realtime,
                                 pmr_pkg::OUT_W'(e.ray), e.refl, m_tdata, m_tuser);
                        fails = fails + 1;
                    end
                end
            end
            if (hold_long && hold_cnt < 200)
            begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap  <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    snk_gap <= $urandom_range(1, 6);
            end
        end
    end

    initial
    begin
        pmr_pkg::ray_t r;
        fails = 0; sent = 0; got = 0; calm = 1'b0; hold_long = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        mir_z = 0; mir_rad = 0; fr_re = 65536; fr_im = 0; hit_count = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: radius zero, only an axis hit reflects
        r = '0; r.pos_z = -32'sd65536; r.dir_z = 18'sd65536; r.amp_re = 18'sd40000;
        ray_q.push_back(r);
        drain();

        set_mirror(32'sd655360, 32'h7FFF_FFFF, 18'sd46341, -18'sd46341);
        r = '0; r.dir_z = 18'sd65536; r.amp_re = 18'sd65536; r.amp_im = -18'sd65536;
        r.path_len = 32'hFFFF_FFF0; r.bounces = 8'hFF;
        ray_q.push_back(r);                      // hit with saturation
        r.dir_z = 18'h20000; r.pos_z = 32'h7FFF_FFFF;
        ray_q.push_back(r);                      // most negative dir_z
        r.dir_z = 0;
        ray_q.push_back(r);                      // parallel
        r.dir_z = 18'sd65536; r.pos_z = 32'sd655360;
        ray_q.push_back(r);                      // on the plane, t zero
        r.pos_z = 32'sd655361; r.dir_z = 18'h1FFFF;
        ray_q.push_back(r);                      // tiny distance
        r.pos_z = 32'sd1000000; r.dir_z = 18'sd65536;
        ray_q.push_back(r);                      // behind
        r.pos_z = 32'h8000_0000; r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000;
        r.dir_x = 18'h1FFFF; r.dir_y = 18'h20000; r.dir_z = 18'sd1;
        ray_q.push_back(r);                      // huge hit point
        r = '0; r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h7FFF_FFFF;
        r.pos_z = -32'sd65536; r.dir_z = 18'sd65536;
        ray_q.push_back(r);                      // corner outside circle
        r = '1; r.dir_z = 18'sd3;
        ray_q.push_back(r);
        drain();

        set_mirror(32'h8000_0000, 32'sd100, 18'h20000, 18'h1FFFF);
        r = '0; r.pos_z = 32'h7FFF_FFFF; r.dir_z = -18'sd65536;
        r.amp_re = 18'h1FFFF; r.amp_im = 18'h20000;
        ray_q.push_back(r);
        drain();

        // random phases through several mirror settings
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_mirror(32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'sd65536, 18'sd0);
                1: set_mirror(32'sd0, 32'sd0, -18'sd65536, 18'sd65536);
                default: set_mirror($urandom, $urandom_range(0, 3) == 0 ? $urandom
                                    : $urandom_range(0, 1 << 24),
                                    18'($urandom), 18'($urandom));
            endcase
            if (ph == 6)
                calm = 1'b1;
            for (int k = 0; k < 200; k++)
                ray_q.push_back(rnd_ray($urandom_range(0, 3) != 0));
            if (ph == 3)
            begin
                @(posedge clk);
                hold_long = 1'b1;
            end
            drain();
            hold_long = 1'b0;
        end

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
